// File: src/t0pbe_pkg.sv
// Package for the T=0 procedure byte engine: codes, widths, limits and the
// configuration and result structs shared by the engine's modules.
// No dependencies.
package t0pbe_pkg;

    localparam int RESP_BUF_BYTES = 258;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_INS_CODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_APDU_CASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_LIMIT   = 2'd3;

    localparam logic [1:0] CASE_NO_DATA   = 2'd1;
    localparam logic [1:0] CASE_FROM_CARD = 2'd2;
    localparam logic [1:0] CASE_TO_CARD   = 2'd3;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_ONE  = 2'd1;
    localparam logic [1:0] SEND_ALL  = 2'd2;

    localparam logic [7:0] ACK_MASK   = 8'hFE;
    localparam logic [7:0] NULL_BYTE  = 8'h60;
    localparam logic [7:0] NIBBLE_HI  = 8'hF0;
    localparam logic [7:0] SW1_6X     = 8'h60;
    localparam logic [7:0] SW1_9X     = 8'h90;

    localparam logic [8:0] RESP_LIMIT_RST = 9'd258;
    localparam logic [8:0] MIN_LIMIT      = 9'd2;
    localparam logic [8:0] STATUS_BYTES   = 9'd2;
    localparam logic [8:0] RCV_MAX        = 9'd511;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PROC   = 3'd1,
        PH_SINGLE = 3'd2,
        PH_SW2    = 3'd3,
        PH_BULK   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] ins_code;
        logic [1:0] apdu_case;
        logic [7:0] transfer_len;
        logic [8:0] resp_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0] send_kind;
        logic [7:0] send_index;
        logic [7:0] send_count;
        logic       resp_write;
        logic [8:0] resp_index;
        logic [7:0] resp_byte;
        logic       done_res;
        logic       fail;
        logic [8:0] resp_len;
    } t_result;

endpackage

// File: src/t0pbe_cfg_regs.sv
// Configuration register file of the T=0 procedure byte engine.
// Depends on t0pbe_pkg.
module t0pbe_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [t0pbe_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [t0pbe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output t0pbe_pkg::t_cfg                   o_cfg
);
    import t0pbe_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_INS_CODE:     n_cfg.ins_code     = i_cfg_data[7:0];
                REG_APDU_CASE:    n_cfg.apdu_case    = i_cfg_data[1:0];
                REG_TRANSFER_LEN: n_cfg.transfer_len = i_cfg_data[7:0];
                REG_RESP_LIMIT:   n_cfg.resp_limit   = i_cfg_data[8:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ins_code     <= '0;
            r_cfg.apdu_case    <= CASE_NO_DATA;
            r_cfg.transfer_len <= '0;
            r_cfg.resp_limit   <= RESP_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/t0pbe_core.sv
// Procedure byte classification, exchange state and counters; produces the
// result of each accepted transaction combinationally. Depends on t0pbe_pkg.
module t0pbe_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic               i_action,
    input  logic [7:0]         i_card_byte,
    input  t0pbe_pkg::t_cfg    i_cfg,
    output t0pbe_pkg::t_result o_res
);
    import t0pbe_pkg::*;

    t_phase     r_phase, n_phase;
    logic [8:0] r_rcv,   n_rcv;
    logic [7:0] r_sent,  n_sent;
    logic [8:0] r_bulk,  n_bulk;

    logic [10:0] lim_wide;
    logic [8:0]  lim_clamp;
    logic [8:0]  eff_lim;
    logic [8:0]  kept;
    logic [8:0]  status_base;
    logic        data_slot;
    logic [8:0]  rcv_inc;
    logic        is_ack, is_inv, is_null, is_sw1;
    logic        to_card, from_card;
    logic        over_send, overrun;
    logic [8:0]  len9;

    assign lim_wide  = (11'(i_cfg.resp_limit) > 11'(RESP_BUF_BYTES)) ?
                       11'(RESP_BUF_BYTES) : 11'(i_cfg.resp_limit);
    assign lim_clamp = lim_wide[8:0];
    assign eff_lim   = (lim_clamp < MIN_LIMIT) ? MIN_LIMIT : lim_clamp;
    assign kept      = eff_lim - STATUS_BYTES;
    assign data_slot = r_rcv < kept;
    assign status_base = data_slot ? r_rcv : kept;
    assign rcv_inc   = (r_rcv < RCV_MAX) ? r_rcv + 9'd1 : r_rcv;

    assign is_ack  = (i_card_byte & ACK_MASK) == (i_cfg.ins_code & ACK_MASK);
    assign is_inv  = ((~i_card_byte) & ACK_MASK) == (i_cfg.ins_code & ACK_MASK);
    assign is_null = i_card_byte == NULL_BYTE;
    assign is_sw1  = ((i_card_byte & NIBBLE_HI) == SW1_6X) ||
                     ((i_card_byte & NIBBLE_HI) == SW1_9X);

    assign to_card   = i_cfg.apdu_case == CASE_TO_CARD;
    assign from_card = i_cfg.apdu_case == CASE_FROM_CARD;
    assign len9      = {1'b0, i_cfg.transfer_len};
    assign over_send = r_sent >= i_cfg.transfer_len;
    assign overrun   = r_rcv > len9;

    // next state and counters
    always_comb begin
        n_phase = r_phase;
        n_rcv   = r_rcv;
        n_sent  = r_sent;
        n_bulk  = r_bulk;
        if (i_take) begin
            if (i_action == ACT_START) begin
                n_phase = PH_PROC;
                n_rcv   = '0;
                n_sent  = '0;
                n_bulk  = '0;
            end else begin
                unique case (r_phase)
                    PH_IDLE: ;
                    PH_PROC: begin
                        if (is_ack) begin
                            if (to_card) begin
                                if (over_send) n_phase = PH_IDLE;
                                else           n_sent  = i_cfg.transfer_len;
                            end else if (from_card) begin
                                if (overrun) begin
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_bulk  = len9 - r_rcv + STATUS_BYTES;
                                    n_phase = PH_BULK;
                                end
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end else if (is_inv) begin
                            if (to_card) begin
                                if (over_send) n_phase = PH_IDLE;
                                else           n_sent  = r_sent + 8'd1;
                            end else if (from_card) begin
                                n_phase = PH_SINGLE;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end else if (is_null) begin
                            n_phase = PH_PROC;
                        end else if (is_sw1) begin
                            n_phase = PH_SW2;
                        end
                    end
                    PH_SINGLE: begin
                        n_rcv   = rcv_inc;
                        n_phase = PH_PROC;
                    end
                    PH_SW2: n_phase = PH_IDLE;
                    PH_BULK: begin
                        if (r_bulk > STATUS_BYTES) begin
                            n_rcv  = rcv_inc;
                            n_bulk = r_bulk - 9'd1;
                        end else if (r_bulk == STATUS_BYTES) begin
                            n_bulk = 9'd1;
                        end else begin
                            n_bulk  = '0;
                            n_phase = PH_IDLE;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // result of the transaction
    always_comb begin
        o_res = '0;
        if (i_action == ACT_BYTE) begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_PROC: begin
                    if (is_ack || is_inv) begin
                        if (to_card) begin
                            if (over_send) begin
                                o_res.fail = 1'b1;
                            end else begin
                                o_res.send_kind  = is_ack ? SEND_ALL : SEND_ONE;
                                o_res.send_index = r_sent;
                                o_res.send_count = is_ack ?
                                    i_cfg.transfer_len - r_sent : 8'd1;
                            end
                        end else if (from_card) begin
                            o_res.fail = is_ack && overrun;
                        end else begin
                            o_res.fail = 1'b1;
                        end
                    end else if (!is_null && is_sw1) begin
                        o_res.resp_write = 1'b1;
                        o_res.resp_index = status_base;
                        o_res.resp_byte  = i_card_byte;
                    end
                end
                PH_SINGLE: begin
                    o_res.resp_write = data_slot;
                    o_res.resp_index = data_slot ? r_rcv : '0;
                    o_res.resp_byte  = data_slot ? i_card_byte : '0;
                end
                PH_SW2: begin
                    o_res.resp_write = 1'b1;
                    o_res.resp_index = status_base + 9'd1;
                    o_res.resp_byte  = i_card_byte;
                    o_res.done_res   = 1'b1;
                    o_res.resp_len   = status_base + STATUS_BYTES;
                end
                PH_BULK: begin
                    if (r_bulk > STATUS_BYTES) begin
                        o_res.resp_write = data_slot;
                        o_res.resp_index = data_slot ? r_rcv : '0;
                        o_res.resp_byte  = data_slot ? i_card_byte : '0;
                    end else if (r_bulk == STATUS_BYTES) begin
                        o_res.resp_write = 1'b1;
                        o_res.resp_index = status_base;
                        o_res.resp_byte  = i_card_byte;
                    end else begin
                        o_res.resp_write = 1'b1;
                        o_res.resp_index = status_base + 9'd1;
                        o_res.resp_byte  = i_card_byte;
                        o_res.done_res   = 1'b1;
                        o_res.resp_len   = status_base + STATUS_BYTES;
                    end
                end
                default: o_res = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_rcv   <= '0;
            r_sent  <= '0;
            r_bulk  <= '0;
        end else begin
            r_phase <= n_phase;
            r_rcv   <= n_rcv;
            r_sent  <= n_sent;
            r_bulk  <= n_bulk;
        end
    end

endmodule

// File: src/t0pbe_out_reg.sv
// Result register of the T=0 procedure byte engine; reloads whenever it is
// empty or being drained. Depends on t0pbe_pkg.
module t0pbe_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t0pbe_pkg::t_result i_res,
    input  logic               i_stall,
    output logic               o_busy,
    output logic               o_valid,
    output t0pbe_pkg::t_result o_res
);
    import t0pbe_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_busy = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_busy) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && !o_busy) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: src/t0_procedure_byte_engine.sv
// T=0 procedure byte engine, top level. Uses t0pbe_pkg, t0pbe_cfg_regs,
// t0pbe_core and t0pbe_out_reg.
// A result is registered and shown in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless i_stall holds the output; the single result register sets it.
// Reset (synchronous, active low): phase idle, counters zero, registers at
// their defaults, output register empty.
module t0_procedure_byte_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [t0pbe_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [t0pbe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_action,
    input  logic [7:0]                        i_card_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_send_kind,
    output logic [7:0]                        o_send_index,
    output logic [7:0]                        o_send_count,
    output logic                              o_resp_write,
    output logic [8:0]                        o_resp_index,
    output logic [7:0]                        o_resp_byte,
    output logic                              o_done_res,
    output logic                              o_fail,
    output logic [8:0]                        o_resp_len
);
    import t0pbe_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    t_result out_res;
    logic    take;

    assign take = i_valid && !o_stall;

    t0pbe_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    t0pbe_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_action    (i_action),
        .i_card_byte (i_card_byte),
        .i_cfg       (cfg),
        .o_res       (core_res)
    );

    t0pbe_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_valid),
        .i_res   (core_res),
        .i_stall (i_stall),
        .o_busy  (o_stall),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_send_kind  = out_res.send_kind;
    assign o_send_index = out_res.send_index;
    assign o_send_count = out_res.send_count;
    assign o_resp_write = out_res.resp_write;
    assign o_resp_index = out_res.resp_index;
    assign o_resp_byte  = out_res.resp_byte;
    assign o_done_res   = out_res.done_res;
    assign o_fail       = out_res.fail;
    assign o_resp_len   = out_res.resp_len;

endmodule

// File: src/t0pbe_checker.sv
// Port-level checks for the T=0 procedure byte engine, bound to the top level.
// Depends on t0pbe_pkg and t0_procedure_byte_engine.
module t0pbe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       i_action,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_send_kind,
    input logic [7:0] o_send_index,
    input logic [7:0] o_send_count,
    input logic       o_resp_write,
    input logic [8:0] o_resp_index,
    input logic       o_done_res,
    input logic       o_fail,
    input logic [8:0] o_resp_len
);
    import t0pbe_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_resp_index) && $stable(o_send_kind))
        else $error("stalled result changed");

    a_end_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_done_res && o_fail))
        else $error("done and fail together");

    a_no_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_send_kind == SEND_NONE) |-> (o_send_count == 8'd0) &&
        (o_send_index == 8'd0))
        else $error("send fields set without a send request");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> o_resp_len == 9'd0)
        else $error("response length without done");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_action == ACT_START) |=> o_valid &&
        (o_send_kind == SEND_NONE) && !o_resp_write && !o_done_res && !o_fail)
        else $error("start transaction gave a non-empty result");

endmodule

bind t0_procedure_byte_engine t0pbe_checker u_t0pbe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_action     (i_action),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_send_kind  (o_send_kind),
    .o_send_index (o_send_index),
    .o_send_count (o_send_count),
    .o_resp_write (o_resp_write),
    .o_resp_index (o_resp_index),
    .o_done_res   (o_done_res),
    .o_fail       (o_fail),
    .o_resp_len   (o_resp_len)
);
